// ===== rtl/bmpdec_pkg.sv =====
// shared constants and types for the bmp stream pixel decoder
`timescale 1ns / 1ps

package bmpdec_pkg;

    // image size bounds
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);

    typedef logic [WIDTH_W-1:0]  width_t;
    typedef logic [HEIGHT_W-1:0] height_t;

    // result kinds
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_PIXEL     = 3'd0;
    localparam kind_t KIND_SIGNATURE = 3'd1;
    localparam kind_t KIND_HEADER    = 3'd2;
    localparam kind_t KIND_DEPTH     = 3'd3;
    localparam kind_t KIND_SIZE      = 3'd4;
    localparam kind_t KIND_TRUNC     = 3'd5;

    // decoder phases
    typedef logic [2:0] phase_t;
    localparam phase_t PH_FILE  = 3'd0;
    localparam phase_t PH_DIB   = 3'd1;
    localparam phase_t PH_SKIP  = 3'd2;
    localparam phase_t PH_PIXEL = 3'd3;
    localparam phase_t PH_PAD   = 3'd4;
    localparam phase_t PH_DONE  = 3'd5;
    localparam phase_t PH_HALT  = 3'd6;

    // bytes per pixel codes
    localparam logic [2:0] BPP_24 = 3'd3;
    localparam logic [2:0] BPP_32 = 3'd4;

endpackage

// ===== rtl/bmpdec_byte_if.sv =====
// valid/ready channel carrying one file byte per transfer
`timescale 1ns / 1ps

interface bmpdec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/bmpdec_pixel_if.sv =====
// valid/ready channel carrying one decoded pixel or error per transfer
`timescale 1ns / 1ps

interface bmpdec_pixel_if import bmpdec_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    kind_t      kind;
    logic       row_end;
    logic       image_end;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output kind, output row_end, output image_end, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input kind, input row_end, input image_end, output ready);
endinterface

// ===== rtl/bmp_stream_pixel_decoder.sv =====
// bmp byte stream decoder: header parse, padding drop, bgr to rgb pixel output
// latency: a result is valid in the cycle after the byte that causes it is transferred
// throughput: one byte per cycle while the input is not stalled; decoder state updates only on a transferred byte
// the input stalls only while the single output register holds a result not yet taken
// reset: asynchronous, active low; returns to the file header phase with all counts at zero
// a byte marked last also returns all decoder state to the reset values
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder import bmpdec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bmpdec_byte_if.sink      stream,
    bmpdec_pixel_if.source   pixels
);

    // header byte positions
    localparam logic [4:0] POS_SIG_LOW  = 5'd1 - 5'd1;
    localparam logic [4:0] POS_SIG_HIGH = 5'd1;
    localparam logic [4:0] POS_OFF_LO   = 5'd10;
    localparam logic [4:0] POS_OFF_HI   = 5'd13;
    localparam logic [4:0] POS_DIB_LO   = 5'd14;
    localparam logic [4:0] POS_DIB_HI   = 5'd17;
    localparam logic [4:0] POS_WID_LO   = 5'd18;
    localparam logic [4:0] POS_WID_HI   = 5'd21;
    localparam logic [4:0] POS_HGT_LO   = 5'd22;
    localparam logic [4:0] POS_HGT_HI   = 5'd25;
    localparam logic [4:0] POS_DEP_LO   = 5'd28;
    localparam logic [4:0] POS_DEP_HI   = 5'd29;
    localparam logic [7:0] SIG_B        = 8'h42;
    localparam logic [7:0] SIG_M        = 8'h4D;
    localparam logic [31:0] MIN_DIB     = 32'd24;
    localparam logic [32:0] FILE_HDR    = 33'd14;
    localparam logic [31:0] DIB_END_OFS = 32'd13;
    localparam logic [15:0] DEPTH_24    = 16'd24;
    localparam logic [15:0] DEPTH_32    = 16'd32;

    // decoder state
    phase_t       phase_reg, phase_next;
    logic [31:0]  pos_reg, pos_next;
    logic [31:0]  offset_reg, offset_next;
    logic [31:0]  dib_reg, dib_next;
    logic [31:0]  dib_end_reg, dib_end_next;
    width_t       width_reg, width_next;
    logic         width_big_reg, width_big_next;
    height_t      height_reg, height_next;
    logic         height_big_reg, height_big_next;
    logic [15:0]  depth_reg, depth_next;
    logic [2:0]   bpp_reg, bpp_next;
    width_t       col_reg, col_next;
    height_t      row_reg, row_next;
    logic [1:0]   bip_reg, bip_next;
    logic [1:0]   pad_reg, pad_next;
    logic [7:0]   sig_reg, sig_next;
    logic [7:0]   pb_reg [3];
    logic         pb_we;

    // output register
    logic         out_valid_reg;
    logic [7:0]   red_reg, green_reg, blue_reg, alpha_reg;
    kind_t        kind_reg;
    logic         row_end_reg, image_end_reg;

    // per-byte result
    logic         res_valid;
    logic [7:0]   res_red, res_green, res_blue, res_alpha;
    kind_t        res_kind;
    logic         res_row_end, res_image_end;

    logic         in_fire;
    logic [7:0]   byte_in;
    logic         last_in;

    assign in_fire = stream.valid && stream.ready;
    assign byte_in = stream.data_byte;
    assign last_in = stream.last_byte;
    assign stream.ready = !out_valid_reg || pixels.ready;

    // next state and result for the byte on the input
    always_comb
    begin
        logic        small_pos;
        logic [4:0]  p5;
        logic [31:0] pos_inc;
        logic [31:0] lane_val;
        logic        dib_end_hit;
        logic        pix_done;
        logic [2:0]  bip_inc;
        width_t      col_inc;
        height_t     row_inc;
        logic [1:0]  pad_dec;
        kind_t       err;

        small_pos = (pos_reg[31:5] == '0);
        p5        = pos_reg[4:0];
        pos_inc   = pos_reg + 32'd1;
        // header fields start at positions equal to 2 mod 4 (depth at 0 mod 4)
        lane_val  = {24'd0, byte_in} << {(p5[1:0] - 2'd2), 3'b000};
        bip_inc   = {1'b0, bip_reg} + 3'd1;
        col_inc   = col_reg + width_t'(1);
        row_inc   = row_reg + height_t'(1);
        pad_dec   = (pad_reg != 2'd0) ? (pad_reg - 2'd1) : 2'd0;
        dib_end_hit = 1'b0;
        pix_done  = 1'b0;
        err       = KIND_PIXEL;

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        offset_next     = offset_reg;
        dib_next        = dib_reg;
        dib_end_next    = dib_end_reg;
        width_next      = width_reg;
        width_big_next  = width_big_reg;
        height_next     = height_reg;
        height_big_next = height_big_reg;
        depth_next      = depth_reg;
        bpp_next        = bpp_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        bip_next        = bip_reg;
        pad_next        = pad_reg;
        sig_next        = sig_reg;
        pb_we           = 1'b0;

        res_valid     = 1'b0;
        res_red       = (bip_reg == 2'd2) ? byte_in : pb_reg[2];
        res_green     = pb_reg[1];
        res_blue      = pb_reg[0];
        res_alpha     = (bpp_reg == BPP_32) ? byte_in : 8'd0;
        res_kind      = KIND_PIXEL;
        res_row_end   = 1'b0;
        res_image_end = 1'b0;

        unique case (phase_reg)
            PH_FILE, PH_DIB:
            begin
                // field capture by byte position
                if (small_pos && p5 == POS_SIG_LOW)
                begin
                    sig_next = byte_in;
                end
                else if (small_pos && p5 == POS_SIG_HIGH)
                begin
                    if (!(sig_reg == SIG_B && byte_in == SIG_M))
                        err = KIND_SIGNATURE;
                end
                else if (small_pos && p5 >= POS_OFF_LO && p5 <= POS_OFF_HI)
                begin
                    offset_next = offset_reg | lane_val;
                end
                else if (small_pos && p5 >= POS_DIB_LO && p5 <= POS_DIB_HI)
                begin
                    dib_next = dib_reg | lane_val;
                    if (p5 == POS_DIB_HI)
                    begin
                        dib_end_next = dib_next + DIB_END_OFS;
                        if (dib_next < MIN_DIB ||
                            {1'b0, offset_reg} < FILE_HDR + {1'b0, dib_next})
                            err = KIND_HEADER;
                    end
                end
                else if (small_pos && p5 >= POS_WID_LO && p5 <= POS_WID_HI)
                begin
                    width_next     = width_reg | lane_val[WIDTH_W-1:0];
                    width_big_next = width_big_reg | (|lane_val[31:WIDTH_W]);
                end
                else if (small_pos && p5 >= POS_HGT_LO && p5 <= POS_HGT_HI)
                begin
                    height_next     = height_reg | lane_val[HEIGHT_W-1:0];
                    height_big_next = height_big_reg | (|lane_val[31:HEIGHT_W]);
                end
                else if (small_pos && (p5 == POS_DEP_LO || p5 == POS_DEP_HI))
                begin
                    depth_next = depth_reg | (p5[0] ? {byte_in, 8'd0} : {8'd0, byte_in});
                end

                // end of dib header: depth then size checks
                dib_end_hit = !(small_pos && p5 <= POS_DIB_HI) && (pos_reg == dib_end_reg);
                if (err == KIND_PIXEL && dib_end_hit)
                begin
                    if (depth_reg == DEPTH_24)
                        bpp_next = BPP_24;
                    else if (depth_reg == DEPTH_32)
                        bpp_next = BPP_32;
                    else
                        err = KIND_DEPTH;
                    if (err == KIND_PIXEL &&
                        ((width_reg == '0 && !width_big_reg) || width_big_reg ||
                         width_reg > width_t'(MAX_WIDTH) ||
                         (height_reg == '0 && !height_big_reg) || height_big_reg ||
                         height_reg > height_t'(MAX_HEIGHT)))
                        err = KIND_SIZE;
                    if (err == KIND_PIXEL)
                        phase_next = (offset_reg == pos_inc) ? PH_PIXEL : PH_SKIP;
                end
                else if (err == KIND_PIXEL && pos_inc >= 32'd14)
                begin
                    phase_next = PH_DIB;
                end
                pos_next = pos_inc;
            end
            PH_SKIP:
            begin
                if (pos_inc >= offset_reg)
                    phase_next = PH_PIXEL;
                pos_next = pos_inc;
            end
            PH_PIXEL:
            begin
                pb_we = (bip_reg != 2'd3);
                if (bip_inc >= bpp_reg)
                begin
                    pix_done = 1'b1;
                    bip_next = 2'd0;
                    if (col_inc >= width_reg)
                    begin
                        res_row_end = 1'b1;
                        col_next    = '0;
                        row_next    = row_inc;
                        if (row_inc >= height_reg)
                        begin
                            res_image_end = 1'b1;
                            phase_next    = PH_DONE;
                        end
                        else if (bpp_reg == BPP_24)
                        begin
                            // 3*width mod 4 padding works out to width mod 4
                            pad_next = width_reg[1:0];
                            if (width_reg[1:0] != 2'd0)
                                phase_next = PH_PAD;
                        end
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
                else
                begin
                    bip_next = bip_inc[1:0];
                end
            end
            PH_PAD:
            begin
                pad_next = pad_dec;
                if (pad_dec == 2'd0)
                    phase_next = PH_PIXEL;
            end
            default:
            begin
            end
        endcase

        // error, truncation or pixel
        priority if (err != KIND_PIXEL)
        begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res_kind   = err;
        end
        else if (last_in && phase_next != PH_DONE && phase_next != PH_HALT)
        begin
            res_valid = 1'b1;
            res_kind  = KIND_TRUNC;
        end
        else if (pix_done)
        begin
            res_valid = 1'b1;
        end
        else
        begin
            res_valid = 1'b0;
        end

        if (res_kind != KIND_PIXEL)
        begin
            res_red       = 8'd0;
            res_green     = 8'd0;
            res_blue      = 8'd0;
            res_alpha     = 8'd0;
            res_row_end   = 1'b0;
            res_image_end = 1'b0;
        end

        // end of file returns everything to reset
        if (last_in)
        begin
            phase_next      = PH_FILE;
            pos_next        = '0;
            offset_next     = '0;
            dib_next        = '0;
            dib_end_next    = '0;
            width_next      = '0;
            width_big_next  = 1'b0;
            height_next     = '0;
            height_big_next = 1'b0;
            depth_next      = '0;
            bpp_next        = '0;
            col_next        = '0;
            row_next        = '0;
            bip_next        = '0;
            pad_next        = '0;
            sig_next        = '0;
        end
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FILE;
            pos_reg        <= '0;
            offset_reg     <= '0;
            dib_reg        <= '0;
            dib_end_reg    <= '0;
            width_reg      <= '0;
            width_big_reg  <= 1'b0;
            height_reg     <= '0;
            height_big_reg <= 1'b0;
            depth_reg      <= '0;
            bpp_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            bip_reg        <= '0;
            pad_reg        <= '0;
            sig_reg        <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            offset_reg     <= offset_next;
            dib_reg        <= dib_next;
            dib_end_reg    <= dib_end_next;
            width_reg      <= width_next;
            width_big_reg  <= width_big_next;
            height_reg     <= height_next;
            height_big_reg <= height_big_next;
            depth_reg      <= depth_next;
            bpp_reg        <= bpp_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            bip_reg        <= bip_next;
            pad_reg        <= pad_next;
            sig_reg        <= sig_next;
        end
    end

    // pixel byte holding registers
    always_ff @(posedge clk)
    begin
        if (in_fire && pb_we)
            pb_reg[bip_reg] <= byte_in;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= res_valid;
        else if (pixels.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            red_reg       <= res_red;
            green_reg     <= res_green;
            blue_reg      <= res_blue;
            alpha_reg     <= res_alpha;
            kind_reg      <= res_kind;
            row_end_reg   <= res_row_end;
            image_end_reg <= res_image_end;
        end
    end

    assign pixels.valid     = out_valid_reg;
    assign pixels.red       = red_reg;
    assign pixels.green     = green_reg;
    assign pixels.blue      = blue_reg;
    assign pixels.alpha     = alpha_reg;
    assign pixels.kind      = kind_reg;
    assign pixels.row_end   = row_end_reg;
    assign pixels.image_end = image_end_reg;

    // checks
    a_image_end_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.image_end |-> pixels.row_end)
        else $error("image end without row end");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.kind != KIND_PIXEL |->
            pixels.red == 8'd0 && pixels.alpha == 8'd0 && !pixels.row_end)
        else $error("error result carries pixel data");

    a_pixel_phase_depth: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXEL |-> bpp_reg == BPP_24 || bpp_reg == BPP_32)
        else $error("pixel phase without a valid depth");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_in |=> phase_reg == PH_FILE && pos_reg == '0 && row_reg == '0)
        else $error("decoder not restarted after last byte");

endmodule
